// ===== src/luhn_pkg.sv =====
// shared types and constants for the luhn card check block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package luhn_pkg;

    localparam int VALUE_W       = 63;
    localparam int DIGIT_W       = 4;
    localparam int COUNT_W       = 5;
    localparam int CLASS_W       = 2;
    localparam int STEP_W        = 6;
    localparam int DEF_MAX_DIGITS = 19;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_INVALID = 2'd0,
        CLASS_3437_15 = 2'd1,
        CLASS_5155_16 = 2'd2,
        CLASS_LEAD4   = 2'd3
    } card_class_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_CONVERT,
        CELL_DRAIN
    } cell_mode_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_REPORT
    } luhn_state_t;

endpackage

`default_nettype wire

// ===== src/luhn_digit_cell.sv =====
// one decimal digit cell of the conversion chain
// shift-add-3 step while converting, digit shift toward the low end while draining
// depends on luhn_pkg
`timescale 1ns / 1ps
`default_nettype none

module luhn_digit_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire luhn_pkg::cell_mode_t         mode,
    input  wire logic                         bit_in,
    input  wire logic [luhn_pkg::DIGIT_W-1:0] digit_in,
    output logic      [luhn_pkg::DIGIT_W-1:0] digit,
    output logic                              carry_out
);
    import luhn_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        carry_out = adj[DIGIT_W-1];
        case (mode)
            CELL_CLEAR:   digit_next = '0;
            CELL_CONVERT: digit_next = {adj[DIGIT_W-2:0], bit_in};
            CELL_DRAIN:   digit_next = digit_in;
            default:      digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

// ===== src/luhn_scan.sv =====
// luhn sum, digit count and leading digits, one digit per step, low digit first
// also derives the card class from the accumulated values
// depends on luhn_pkg
`timescale 1ns / 1ps
`default_nettype none

module luhn_scan (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire luhn_pkg::scan_ctrl_t         ctrl,
    input  wire logic [luhn_pkg::DIGIT_W-1:0] digit,
    input  wire logic [luhn_pkg::COUNT_W-1:0] index,
    output luhn_pkg::card_class_t             card_class,
    output logic                              sum_ok,
    output logic      [luhn_pkg::COUNT_W-1:0] count
);
    import luhn_pkg::*;

    logic [DIGIT_W-1:0] sum_reg,    sum_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [DIGIT_W-1:0] lead_reg,   lead_next;
    logic [DIGIT_W-1:0] second_reg, second_next;
    logic [DIGIT_W-1:0] prev_reg,   prev_next;
    logic [DIGIT_W:0]   dbl;
    logic [DIGIT_W:0]   dbl_fold;
    logic [DIGIT_W-1:0] contrib;
    logic [DIGIT_W:0]   acc;
    logic [DIGIT_W:0]   acc_fold;

    always_comb
    begin
        dbl      = {digit, 1'b0};
        dbl_fold = dbl - 5'd9;
        // index bit 0 set means an even position counted from 1
        if (index[0])
        begin
            contrib = (dbl >= 5'd10) ? dbl_fold[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
        end
        else
        begin
            contrib = digit;
        end
        acc      = {1'b0, sum_reg} + {1'b0, contrib};
        acc_fold = acc - 5'd10;

        sum_next    = sum_reg;
        count_next  = count_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        prev_next   = prev_reg;
        if (ctrl.clear)
        begin
            sum_next    = '0;
            count_next  = '0;
            lead_next   = '0;
            second_next = '0;
            prev_next   = '0;
        end
        else if (ctrl.step)
        begin
            sum_next  = (acc >= 5'd10) ? acc_fold[DIGIT_W-1:0] : acc[DIGIT_W-1:0];
            prev_next = digit;
            // highest nonzero digit seen so far is the leading one
            if (digit != '0)
            begin
                count_next  = index + 5'd1;
                lead_next   = digit;
                second_next = prev_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            count_reg  <= '0;
            lead_reg   <= '0;
            second_reg <= '0;
            prev_reg   <= '0;
        end
        else
        begin
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            lead_reg   <= lead_next;
            second_reg <= second_next;
            prev_reg   <= prev_next;
        end
    end

    always_comb
    begin
        sum_ok     = (sum_reg == '0);
        count      = count_reg;
        card_class = CLASS_INVALID;
        if (sum_ok)
        begin
            if (count_reg == 5'd15 && lead_reg == 4'd3 &&
                (second_reg == 4'd4 || second_reg == 4'd7))
            begin
                card_class = CLASS_3437_15;
            end
            else if (count_reg == 5'd16 && lead_reg == 4'd5 &&
                     second_reg >= 4'd1 && second_reg <= 4'd5)
            begin
                card_class = CLASS_5155_16;
            end
            else if ((count_reg == 5'd16 || count_reg == 5'd13) && lead_reg == 4'd4)
            begin
                card_class = CLASS_LEAD4;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/luhn_check_card_class_top.sv =====
// top level of the luhn card check: sequencer, binary shift register, digit chain
// depends on luhn_pkg, luhn_digit_cell and luhn_scan
`timescale 1ns / 1ps
`default_nettype none

// A transaction starts when start is high while busy is low; card_value is
// sampled then. The number is shifted one bit per cycle into a row of
// MAX_DIGITS decimal digit cells, then the digits are shifted out of the row
// one per cycle, low digit first, into the luhn accumulator, and the report
// state registers the result. done is high for one cycle with card_class,
// checksum_ok and digit_count. The result must be taken in that cycle, there
// is no way to hold it. busy drops as done rises, so a new transaction may
// start in the same cycle; a new number is taken only after the previous one
// has been reported. A number with more than MAX_DIGITS digits reports class
// invalid, checksum_ok 0 and digit_count MAX_DIGITS.
module luhn_check_card_class_top #(
    parameter int MAX_DIGITS = luhn_pkg::DEF_MAX_DIGITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [luhn_pkg::VALUE_W-1:0] card_value,
    output logic                              busy,
    output logic                              done,
    output logic      [luhn_pkg::CLASS_W-1:0] card_class,
    output logic                              checksum_ok,
    output logic      [luhn_pkg::COUNT_W-1:0] digit_count
);
    import luhn_pkg::*;

    luhn_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic               ovf_reg, ovf_next;
    logic               done_reg, done_next;
    logic [CLASS_W-1:0] class_reg, class_next;
    logic               ok_reg, ok_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    cell_mode_t         cell_mode;
    scan_ctrl_t         scan_ctrl;

    logic [DIGIT_W-1:0] cell_digit [MAX_DIGITS];
    logic               cell_carry [MAX_DIGITS];

    card_class_t        scan_class;
    logic               scan_ok;
    logic [COUNT_W-1:0] scan_count;

    genvar k;
    generate
        for (k = 0; k < MAX_DIGITS; k++)
        begin : g_cell
            logic               bit_in;
            logic [DIGIT_W-1:0] digit_in;
            if (k == 0)
            begin : g_first
                assign bit_in = bin_reg[VALUE_W-1];
            end
            else
            begin : g_inner
                assign bit_in = cell_carry[k-1];
            end
            if (k == MAX_DIGITS - 1)
            begin : g_last
                assign digit_in = '0;
            end
            else
            begin : g_body
                assign digit_in = cell_digit[k+1];
            end
            luhn_digit_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .mode      (cell_mode),
                .bit_in    (bit_in),
                .digit_in  (digit_in),
                .digit     (cell_digit[k]),
                .carry_out (cell_carry[k])
            );
        end
    endgenerate

    luhn_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .digit      (cell_digit[0]),
        .index      (step_reg[COUNT_W-1:0]),
        .card_class (scan_class),
        .sum_ok     (scan_ok),
        .count      (scan_count)
    );

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        bin_next        = bin_reg;
        ovf_next        = ovf_reg;
        done_next       = 1'b0;
        class_next      = class_reg;
        ok_next         = ok_reg;
        count_next      = count_reg;
        cell_mode       = CELL_HOLD;
        scan_ctrl.clear = 1'b0;
        scan_ctrl.step  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    bin_next        = card_value;
                    ovf_next        = 1'b0;
                    step_next       = '0;
                    cell_mode       = CELL_CLEAR;
                    scan_ctrl.clear = 1'b1;
                    state_next      = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cell_mode = CELL_CONVERT;
                bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
                // a bit leaving the top cell means the value does not fit
                ovf_next  = ovf_reg | cell_carry[MAX_DIGITS-1];
                if (step_reg == STEP_W'(VALUE_W - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            ST_SCAN:
            begin
                cell_mode      = CELL_DRAIN;
                scan_ctrl.step = 1'b1;
                if (step_reg == STEP_W'(MAX_DIGITS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_REPORT;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            ST_REPORT:
            begin
                done_next = 1'b1;
                if (ovf_reg)
                begin
                    class_next = CLASS_INVALID;
                    ok_next    = 1'b0;
                    count_next = COUNT_W'(MAX_DIGITS);
                end
                else
                begin
                    class_next = scan_class;
                    ok_next    = scan_ok;
                    count_next = scan_count;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        class_reg <= class_next;
        ok_reg    <= ok_next;
        count_reg <= count_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign card_class  = class_reg;
    assign checksum_ok = ok_reg;
    assign digit_count = count_reg;

endmodule

`default_nettype wire
